// File: src/wgm_pkg.sv
// package for the weighted gram matrix block: widths, modes, saturation helper
// no dependencies
`default_nettype none
package wgm_pkg;
  localparam int MaxRows = 16;
  localparam int MaxCols = 32;
  localparam int RowW = 4;
  localparam int ColW = 5;
  localparam int CfgRowW = 5;
  localparam int CfgColW = 6;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 6;
  localparam int ValW = 16;
  localparam int OutW = 48;
  localparam int AccW = 72;

  localparam logic [2:0] ModeWrA = 3'd0;
  localparam logic [2:0] ModeWrD = 3'd1;
  localparam logic [2:0] ModeWrP = 3'd2;
  localparam logic [2:0] ModeComp = 3'd3;
  localparam logic [2:0] ModeRdH = 3'd4;
  localparam logic [2:0] ModeMul = 3'd5;

  localparam logic [CfgIdxW-1:0] RegRows = 1'd0;
  localparam logic [CfgIdxW-1:0] RegCols = 1'd1;

  typedef struct packed {
    logic [2:0]          mode;
    logic [RowW-1:0]     row_index;
    logic [ColW-1:0]     col_index;
    logic signed [ValW-1:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic signed [OutW-1:0] value_out;
    logic [RowW-1:0]        row_out;
    logic                   last_flag;
    logic                   status;
  } out_item_t;

  // saturate a wide signed value to 48 bits
  function automatic logic signed [OutW-1:0] sat48(input logic signed [AccW-1:0] x);
    logic signed [AccW-1:0] mx;
    logic signed [AccW-1:0] mn;
    mx = AccW'(signed'({1'b0, {(OutW-1){1'b1}}}));
    mn = -mx - AccW'(1);
    if (x > mx) return mx[OutW-1:0];
    if (x < mn) return mn[OutW-1:0];
    return x[OutW-1:0];
  endfunction
endpackage
`default_nettype wire

// File: src/wgm_stream_if.sv
// valid/ready channel interfaces for the input and result transactions
// depends on wgm_pkg for the payload types
`default_nettype none
interface wgm_in_if;
  logic valid;
  logic ready;
  wgm_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface wgm_out_if;
  logic valid;
  logic ready;
  wgm_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/wgm_ram.sv
// generic single-port-write ram with registered read
// no dependencies
`default_nettype none
module wgm_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: src/wgm_mac.sv
// shared multiply-accumulate unit: two registered multiply steps, then accumulate
// depends on wgm_pkg
`default_nettype none
module wgm_mac (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic clr_i,
  input  wire logic en_i,
  input  wire logic signed [wgm_pkg::OutW-1:0] a_i,
  input  wire logic signed [wgm_pkg::ValW-1:0] b_i,
  input  wire logic signed [wgm_pkg::ValW-1:0] c_i,
  input  wire logic use_c_i,
  output logic signed [wgm_pkg::AccW-1:0] acc_o
);
  import wgm_pkg::*;
  // stage 1: b*c (or b alone), stage 2: a * stage1 split in two halves
  logic signed [31:0] p1_q;
  logic v1_q, v2_q;
  logic signed [OutW-1:0] a1_q;
  logic signed [AccW-1:0] lo_q, hi_q;
  logic signed [AccW-1:0] acc_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      acc_q <= '0;
    end else begin
      v1_q <= en_i;
      v2_q <= v1_q;
      if (clr_i) acc_q <= '0;
      else if (v2_q) acc_q <= acc_q + lo_q + hi_q;
    end
  end
  always_ff @(posedge clk_i) begin
    p1_q <= use_c_i ? 32'(b_i * c_i) : 32'(b_i);
    a1_q <= a_i;
    // 24x32 unsigned-low and signed-high partial products
    lo_q <= AccW'(signed'({1'b0, a1_q[23:0]}) * p1_q);
    hi_q <= AccW'(signed'(a1_q[OutW-1:24]) * p1_q) <<< 24;
  end
  assign acc_o = acc_q;
endmodule
`default_nettype wire

// File: src/weighted_gram_matrix_and_multiply.sv
// top level of the weighted gram matrix block: sequencer, stores and shared mac
// depends on wgm_pkg, wgm_stream_if, wgm_ram, wgm_mac
//
// One transaction in at a time; ready is low while an item is worked on. Writes
// and bad modes go from idle through the store and output states back to idle;
// reads of H add a state that waits for the ram read. Compute H walks each element
// with an issue pass over the cols terms, a drain of the mac pipeline and a store,
// all done on the single shared multiply-accumulate unit that walks every
// A(i,k)*A(j,k)*d(k) term from the ram read ports. Multiply by p emits one result
// per row, waiting on the output channel between rows. H is Q40.8 truncated toward
// minus infinity and saturated to 48 bits; r is the exact sum of H*p truncated
// the same way. Store contents are undefined until written.
`default_nettype none
module weighted_gram_matrix_and_multiply (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [wgm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [wgm_pkg::CfgDataW-1:0] cfg_data_i,
  wgm_in_if.sink   in_if,
  wgm_out_if.source out_if
);
  import wgm_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StIssue = 3'd1; // stream ram reads into the mac
  localparam logic [2:0] StDrain = 3'd2; // wait for mac pipeline
  localparam logic [2:0] StStore = 3'd3; // write A, d, p or an H element / set result
  localparam logic [2:0] StOut = 3'd4;   // hold result until taken
  localparam logic [2:0] StRdH = 3'd5;   // wait ram read of H

  logic [2:0] st_q, st_d;
  logic [CfgRowW-1:0] rows_q;
  logic [CfgColW-1:0] cols_q;
  in_item_t it_q;
  out_item_t res_q;
  logic [RowW-1:0] i_q, j_q;
  logic [ColW-1:0] k_q;
  logic [2:0] drain_q;
  logic issue_q;
  logic mac_done_q;

  // register clamp
  logic [CfgRowW-1:0] rows_w;
  logic [CfgColW-1:0] cols_w;
  always_comb begin
    rows_w = cfg_data_i[CfgRowW-1:0];
    if (rows_w == '0) rows_w = CfgRowW'(1);
    else if (rows_w > CfgRowW'(MaxRows)) rows_w = CfgRowW'(MaxRows);
    cols_w = cfg_data_i[CfgColW-1:0];
    if (cols_w == '0) cols_w = CfgColW'(1);
    else if (cols_w > CfgColW'(MaxCols)) cols_w = CfgColW'(MaxCols);
  end

  logic acc_in;
  assign acc_in = in_if.valid && in_if.ready;
  assign in_if.ready = (st_q == StIdle);
  assign out_if.valid = (st_q == StOut);
  assign out_if.data = res_q;

  // stores
  logic a_we, d_we, p_we, h_we;
  logic [8:0] a_raddr1, a_raddr2;
  logic [15:0] a_rd1, a_rd2, d_rd, p_rd;
  logic [47:0] h_rd;
  logic [7:0] h_raddr, h_waddr;
  logic signed [OutW-1:0] h_wdata;
  logic in_row, in_col, in_dcol;
  assign in_row = {1'b0, it_q.row_index} < rows_q;
  assign in_col = {1'b0, it_q.col_index} < cols_q;
  assign in_dcol = in_col;

  logic comp_mode;
  assign comp_mode = (it_q.mode == ModeComp);
  assign a_raddr1 = {i_q, k_q};
  assign a_raddr2 = {j_q, k_q};
  // a read of H addresses the element from the store cycle on
  assign h_raddr = (it_q.mode == ModeRdH) ?
                   {it_q.row_index, it_q.col_index[RowW-1:0]} : {i_q, j_q};
  assign h_waddr = {i_q, j_q};

  wgm_ram #(.Width(ValW), .Depth(MaxRows*MaxCols)) u_a1 (
    .clk_i, .we_i(a_we), .waddr_i({it_q.row_index, it_q.col_index}),
    .wdata_i(it_q.value_in), .raddr_i(a_raddr1), .rdata_o(a_rd1));
  wgm_ram #(.Width(ValW), .Depth(MaxRows*MaxCols)) u_a2 (
    .clk_i, .we_i(a_we), .waddr_i({it_q.row_index, it_q.col_index}),
    .wdata_i(it_q.value_in), .raddr_i(a_raddr2), .rdata_o(a_rd2));
  wgm_ram #(.Width(ValW), .Depth(MaxCols)) u_d (
    .clk_i, .we_i(d_we), .waddr_i(it_q.col_index), .wdata_i(it_q.value_in),
    .raddr_i(k_q), .rdata_o(d_rd));
  wgm_ram #(.Width(ValW), .Depth(MaxRows)) u_p (
    .clk_i, .we_i(p_we), .waddr_i(it_q.row_index), .wdata_i(it_q.value_in),
    .raddr_i(j_q), .rdata_o(p_rd));
  wgm_ram #(.Width(OutW), .Depth(MaxRows*MaxRows)) u_h (
    .clk_i, .we_i(h_we), .waddr_i(h_waddr), .wdata_i(h_wdata),
    .raddr_i(h_raddr), .rdata_o(h_rd));

  // mac: compute uses a=A(i,k) sign-extended, b=A(j,k), c=d(k);
  // multiply uses a=H(i,j), b=p(j)
  logic mac_clr;
  logic signed [AccW-1:0] acc;
  wgm_mac u_mac (
    .clk_i, .rst_ni, .clr_i(mac_clr), .en_i(issue_q),
    .a_i(comp_mode ? OutW'(signed'(a_rd1)) : signed'(h_rd)),
    .b_i(comp_mode ? signed'(a_rd2) : signed'(p_rd)),
    .c_i(signed'(d_rd)), .use_c_i(comp_mode), .acc_o(acc));

  // truncate toward minus infinity by arithmetic shift
  logic signed [AccW-1:0] sh;
  logic signed [AccW-1:0] hval;
  assign sh = acc >>> 16;
  assign hval = sh + ((i_q == j_q) ? AccW'(256) : AccW'(0));
  assign h_wdata = sat48(hval);

  logic last_k, last_j, last_i;
  assign last_k = ({1'b0, k_q} == cols_q - CfgColW'(1));
  assign last_j = ({1'b0, j_q} == rows_q - CfgRowW'(1));
  assign last_i = ({1'b0, i_q} == rows_q - CfgRowW'(1));
  logic last_step;
  assign last_step = comp_mode ? last_k : last_j;

  always_comb begin
    st_d = st_q;
    a_we = 1'b0; d_we = 1'b0; p_we = 1'b0; h_we = 1'b0;
    mac_clr = 1'b0;
    case (st_q)
      StIdle: if (acc_in) st_d = StStore;
      StIssue: if (last_step) st_d = StDrain;
      StDrain: if (drain_q == 3'd0) st_d = StStore;
      StStore: begin
        case (it_q.mode)
          ModeWrA: begin a_we = in_row && in_col; st_d = StOut; end
          ModeWrD: begin d_we = in_dcol; st_d = StOut; end
          ModeWrP: begin p_we = in_row; st_d = StOut; end
          ModeRdH: st_d = StRdH;
          ModeComp: begin
            if (mac_done_q) begin
              h_we = 1'b1;
              mac_clr = 1'b1;
              st_d = (last_i && last_j) ? StOut : StIssue;
            end else begin
              mac_clr = 1'b1;
              st_d = StIssue;
            end
          end
          ModeMul: begin
            mac_clr = !mac_done_q;
            st_d = mac_done_q ? StOut : StIssue;
          end
          default: st_d = StOut;
        endcase
      end
      StRdH: st_d = StOut;
      StOut: if (out_if.ready) begin
        if (it_q.mode == ModeMul && !res_q.last_flag) begin
          mac_clr = 1'b1;
          st_d = StIssue;
        end else begin
          st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  // mac_done_q marks the store pass that follows a drain (result pass)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      rows_q <= CfgRowW'(MaxRows);
      cols_q <= CfgColW'(MaxCols);
      i_q <= '0; j_q <= '0; k_q <= '0;
      drain_q <= '0;
      issue_q <= 1'b0;
      mac_done_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i && cfg_idx_i == RegRows) rows_q <= rows_w;
      if (cfg_we_i && cfg_idx_i == RegCols) cols_q <= cols_w;
      // ram read data is registered, so the issue flag is registered to line up with it
      issue_q <= (st_q == StIssue);
      mac_done_q <= (st_q == StDrain) && (drain_q == 3'd0);
      if (st_q == StIssue && last_step) drain_q <= 3'd4;
      else if (drain_q != 3'd0) drain_q <= drain_q - 3'd1;
      case (st_q)
        StIdle: begin i_q <= '0; j_q <= '0; k_q <= '0; end
        StIssue: begin
          if (comp_mode) k_q <= last_k ? '0 : k_q + ColW'(1);
          else j_q <= last_j ? '0 : j_q + RowW'(1);
        end
        StStore: if (comp_mode && mac_done_q) begin
          if (last_j) begin j_q <= '0; i_q <= i_q + RowW'(1); end
          else j_q <= j_q + RowW'(1);
        end
        StOut: if (out_if.ready && it_q.mode == ModeMul) i_q <= i_q + RowW'(1);
        default: ;
      endcase
    end
  end

  logic signed [AccW-1:0] rsum;
  assign rsum = acc >>> 16;

  always_ff @(posedge clk_i) begin
    if (acc_in) it_q <= in_if.data;
    case (st_q)
      StStore: begin
        res_q.value_out <= '0;
        res_q.row_out <= it_q.row_index;
        res_q.last_flag <= 1'b1;
        res_q.status <= 1'b0;
        case (it_q.mode)
          ModeWrA: res_q.status <= !(in_row && in_col);
          ModeWrD: res_q.status <= !in_dcol;
          ModeWrP: res_q.status <= !in_row;
          ModeComp: res_q.row_out <= '0;
          ModeMul: begin
            res_q.value_out <= sat48(rsum);
            res_q.row_out <= i_q;
            res_q.last_flag <= last_i;
          end
          ModeRdH: ;
          default: begin res_q.row_out <= '0; res_q.status <= 1'b1; end
        endcase
      end
      StRdH: begin
        if (!in_row || {1'b0, it_q.col_index} >= {1'b0, rows_q}) begin
          res_q.value_out <= '0;
          res_q.status <= 1'b1;
        end else begin
          res_q.value_out <= h_rd;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// File: src/wgm_checker.sv
// port-level assertions for the weighted gram matrix block, bound to the top level
// depends on the top-level ports only
`default_nettype none
module wgm_port_props (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic out_last_i
);
  // no new transaction while a result waits
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i) else $error("input taken while result pending");
  // an accepted item blocks input next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i) else $error("ready after accept");
  // result stays until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i) else $error("result dropped");
  // ready only returns after a last result
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && !out_last_i) |=> !in_ready_i)
    else $error("ready before last result");
endmodule

bind weighted_gram_matrix_and_multiply wgm_port_props u_wgm_port_props (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_if.valid),
  .in_ready_i(in_if.ready), .out_valid_i(out_if.valid), .out_ready_i(out_if.ready),
  .out_last_i(out_if.data.last_flag));
`default_nettype wire

// File: tb/sv/wgm_checker.sv
// checker for the weighted gram matrix block: predicts every result and compares
// depends on wgm_pkg and the wgm_in_if / wgm_out_if channel interfaces
module wgm_scoreboard (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [wgm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [wgm_pkg::CfgDataW-1:0] cfg_data_i,
  wgm_in_if in_ch,
  wgm_out_if out_ch,
  output int error_count_o,
  output int pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import wgm_pkg::*;

  logic signed [ValW-1:0] a_mem [MaxRows][MaxCols];
  logic signed [ValW-1:0] d_mem [MaxCols];
  logic signed [ValW-1:0] p_mem [MaxRows];
  longint h_mem [MaxRows][MaxRows];
  int rows_cur = MaxRows;
  int cols_cur = MaxCols;
  out_item_t result_q [$];
  int errors = 0;

  assign error_count_o = errors;
  assign pending_count_o = result_q.size();

  function automatic longint sat_q40(longint x);
    longint mx;
    mx = (longint'(1) <<< (OutW - 1)) - 1;
    if (x > mx) return mx;
    if (x < -mx - 1) return -mx - 1;
    return x;
  endfunction

  function automatic void push_result(longint v, int row, bit last, bit st);
    out_item_t r;
    r.value_out = v[OutW-1:0];
    r.row_out = row[RowW-1:0];
    r.last_flag = last;
    r.status = st;
    result_q = {result_q, r};
  endfunction

  function automatic void predict_results(in_item_t it);
    int row;
    int col;
    longint acc;
    longint prod;
    longint q;
    longint hi;
    longint lo;
    bit bad;
    row = it.row_index;
    col = it.col_index;
    case (it.mode)
      ModeWrA: begin
        bad = (row >= rows_cur) || (col >= cols_cur);
        if (!bad) a_mem[row][col] = it.value_in;
        push_result(0, row, 1'b1, bad);
      end
      ModeWrD: begin
        bad = col >= cols_cur;
        if (!bad) d_mem[col] = it.value_in;
        push_result(0, row, 1'b1, bad);
      end
      ModeWrP: begin
        bad = row >= rows_cur;
        if (!bad) p_mem[row] = it.value_in;
        push_result(0, row, 1'b1, bad);
      end
      ModeComp: begin
        for (int i = 0; i < rows_cur; i++) begin
          for (int j = 0; j < rows_cur; j++) begin
            acc = 0;
            for (int k = 0; k < cols_cur; k++) begin
              acc += longint'(a_mem[i][k]) * longint'(a_mem[j][k]) * longint'(d_mem[k]);
            end
            // floor shift back to Q8 fraction, then add the identity
            acc = acc >>> 16;
            if (i == j) acc += 256;
            h_mem[i][j] = sat_q40(acc);
          end
        end
        push_result(0, 0, 1'b1, 1'b0);
      end
      ModeRdH: begin
        if (row >= rows_cur || col >= rows_cur) push_result(0, row, 1'b1, 1'b1);
        else push_result(h_mem[row][col], row, 1'b1, 1'b0);
      end
      ModeMul: begin
        for (int i = 0; i < rows_cur; i++) begin
          hi = 0;
          lo = 0;
          // split each product so the sum cannot overflow 64 bits
          for (int j = 0; j < rows_cur; j++) begin
            prod = h_mem[i][j] * longint'(p_mem[j]);
            q = prod >>> 16;
            hi += q;
            lo += prod - (q <<< 16);
          end
          push_result(sat_q40(hi + (lo >>> 16)), i, i == rows_cur - 1, 1'b0);
        end
      end
      default: push_result(0, 0, 1'b1, 1'b1);
    endcase
  endfunction

  always @(posedge clk_i) begin
    out_item_t exp_r;
    out_item_t got;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegRows) begin
          rows_cur = int'(cfg_data_i[CfgRowW-1:0]);
          if (rows_cur == 0) rows_cur = 1;
          if (rows_cur > MaxRows) rows_cur = MaxRows;
        end else begin
          cols_cur = int'(cfg_data_i[CfgColW-1:0]);
          if (cols_cur == 0) cols_cur = 1;
          if (cols_cur > MaxCols) cols_cur = MaxCols;
        end
      end
      if (in_ch.valid && in_ch.ready) predict_results(in_ch.data);
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (result_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result transaction %p", $time, got);
        end else begin
          exp_r = result_q.pop_front();
          if (got.value_out !== exp_r.value_out) begin
            errors++;
            $display("%0t: value_out expected %0d actual %0d", $time,
                     exp_r.value_out, got.value_out);
          end
          if (got.row_out !== exp_r.row_out) begin
            errors++;
            $display("%0t: row_out expected %0d actual %0d", $time,
                     exp_r.row_out, got.row_out);
          end
          if (got.last_flag !== exp_r.last_flag) begin
            errors++;
            $display("%0t: last_flag expected %0b actual %0b", $time,
                     exp_r.last_flag, got.last_flag);
          end
          if (got.status !== exp_r.status) begin
            errors++;
            $display("%0t: status expected %0b actual %0b", $time,
                     exp_r.status, got.status);
          end
        end
      end
    end
  end
endmodule

// File: tb/sv/weighted_gram_matrix_and_multiply_test.sv
// top of the weighted gram matrix testbench: clock, reset, stimulus and verdict
// depends on wgm_pkg, the channel interfaces, wgm_scoreboard and the block itself
module weighted_gram_matrix_and_multiply_test;
  timeunit 1ns;
  timeprecision 1ps;
  import wgm_pkg::*;

  localparam int CycleLimit = 3000000;
  localparam int SettleCycles = 16;
  localparam int RandomPerPhase = 5;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = RegRows;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  int error_count;
  int pending_count;
  int cycle_count = 0;

  wgm_in_if in_ch ();
  wgm_out_if out_ch ();

  // percent chance per cycle that the sender or the receiver holds off
  int send_hold = 0;
  int recv_hold = 0;

  // which store entries have been written, so no unwritten entry is ever read
  bit a_done [MaxRows][MaxCols];
  bit d_done [MaxCols];
  bit p_done [MaxRows];
  int rows_eff = MaxRows;
  int cols_eff = MaxCols;

  weighted_gram_matrix_and_multiply uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_if(in_ch),
    .out_if(out_ch)
  );

  wgm_scoreboard checker_inst (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .error_count_o(error_count),
    .pending_count_o(pending_count)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // receiver: one ready decision per cycle
  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_hold);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // one input transaction; valid only drops when a gap is actually taken
  task automatic send_item(logic [2:0] mode, int row, int col, logic [ValW-1:0] val);
    in_item_t it;
    it.mode = mode;
    it.row_index = row[RowW-1:0];
    it.col_index = col[ColW-1:0];
    it.value_in = val;
    while ($urandom_range(99) < send_hold) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    // track writes that land inside the current sizes
    if (mode == ModeWrA && row < rows_eff && col < cols_eff) a_done[row][col] = 1'b1;
    if (mode == ModeWrD && col < cols_eff) d_done[col] = 1'b1;
    if (mode == ModeWrP && row < rows_eff) p_done[row] = 1'b1;
  endtask

  // let every expected result drain, then allow the block to go fully idle
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int data);
    int v;
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data[CfgDataW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    // out-of-range values clamp: zero becomes one, too large becomes the maximum
    if (idx == RegRows) begin
      v = data & 5'h1f;
      rows_eff = (v == 0) ? 1 : (v > MaxRows) ? MaxRows : v;
    end else begin
      v = data & 6'h3f;
      cols_eff = (v == 0) ? 1 : (v > MaxCols) ? MaxCols : v;
    end
  endtask

  function automatic logic [ValW-1:0] pick_value();
    case ($urandom_range(7))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return ValW'($urandom_range(16'hffff));
    endcase
  endfunction

  // fill every entry needed by compute and multiply that is still unwritten
  task automatic fill_stores();
    for (int c = 0; c < cols_eff; c++) begin
      if (!d_done[c]) send_item(ModeWrD, $urandom_range(15), c, pick_value());
    end
    for (int r = 0; r < rows_eff; r++) begin
      if (!p_done[r]) send_item(ModeWrP, r, $urandom_range(31), pick_value());
      for (int c = 0; c < cols_eff; c++) begin
        if (!a_done[r][c]) send_item(ModeWrA, r, c, pick_value());
      end
    end
  endtask

  // random mix over the whole field range; stores stay fully written in range
  task automatic random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 25) send_item(ModeWrA, $urandom_range(15), $urandom_range(31), pick_value());
    else if (pick < 35) send_item(ModeWrD, $urandom_range(15), $urandom_range(31), pick_value());
    else if (pick < 45) send_item(ModeWrP, $urandom_range(15), $urandom_range(31), pick_value());
    else if (pick < 52) send_item(ModeComp, $urandom_range(15), $urandom_range(31),
                                  pick_value());
    else if (pick < 74) send_item(ModeRdH, $urandom_range(15), $urandom_range(31),
                                  pick_value());
    else if (pick < 94) send_item(ModeMul, $urandom_range(15), $urandom_range(31),
                                  pick_value());
    else send_item(3'($urandom_range(7, 6)), $urandom_range(15), $urandom_range(31),
                   pick_value());
  endtask

  // one phase: configure while idle, fill, compute, directed checks, random mix, drain
  task automatic run_phase(int phase, int rows_val, int cols_val);
    case (phase)
      0: begin send_hold = 27; recv_hold = 60; end
      1: begin send_hold = 60; recv_hold = 27; end
      default: begin send_hold = 0; recv_hold = 0; end
    endcase
    write_reg(RegRows, rows_val);
    write_reg(RegCols, cols_val);
    fill_stores();
    send_item(ModeComp, 0, 0, '0);
    send_item(ModeRdH, 0, 0, '0);
    send_item(ModeRdH, rows_eff - 1, rows_eff - 1, '0);
    send_item(ModeMul, 0, 0, '0);
    if (phase == 0) begin
      // unknown modes
      send_item(3'd6, 15, 31, 16'hffff);
      send_item(3'd7, 0, 0, '0);
    end
    if (phase == 1) begin
      // out-of-range writes and reads at the edge of the configured size
      send_item(ModeWrA, rows_eff, 0, 16'h7fff);
      send_item(ModeWrA, 0, cols_eff, 16'h8000);
      send_item(ModeWrD, 0, cols_eff, 16'h1234);
      send_item(ModeWrP, rows_eff, 0, 16'h4321);
      send_item(ModeRdH, rows_eff, 0, '0);
      send_item(ModeRdH, 0, rows_eff, '0);
      send_item(ModeRdH, 15, 31, '0);
    end
    repeat (RandomPerPhase) random_item();
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // zero clamps to one
    run_phase(0, 0, 0);
    run_phase(1, 3, 4);
    // a row count above the maximum clamps to it: all rows in use
    run_phase(2, 31, 2);
    // shrink after compute keeps stored entries
    run_phase(3, 2, 3);
    if (error_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
